@@ rtl/core/cfga_pkg.sv @@
`default_nettype none

package cfga_pkg;

    localparam int FRAME_BITS     = 32;
    localparam int SAMPLE_BITS    = 24;
    localparam int ENV_FRAC_BITS  = 16;
    localparam int CLIP_GAIN_BITS = 16;
    localparam int GAIN_BITS      = 20;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;

    // Register map of the configuration port
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CLIP_LENGTH = 2'd0,
        REG_FADE_IN     = 2'd1,
        REG_FADE_OUT    = 2'd2,
        REG_CLIP_GAIN   = 2'd3
    } cfg_reg_t;

    // Payload that rides along the divider stages
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CLIP_GAIN_BITS-1:0]     clip_gain;
        logic                          in_act;
        logic                          out_act;
    } item_t;

    // One restoring divider lane: partial remainder, quotient so far, divisor
    typedef struct packed {
        logic [FRAME_BITS-1:0]    rem;
        logic [ENV_FRAC_BITS-1:0] quo;
        logic [FRAME_BITS-1:0]    den;
    } div_t;

endpackage

`default_nettype wire

@@ rtl/core/cfga_front.sv @@
`default_nettype none

module cfga_front
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   advance,
    input  wire logic                                   accept,
    input  wire logic                                   cfg_we,
    input  wire logic [cfga_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [cfga_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  wire logic [cfga_pkg::FRAME_BITS-1:0]        position,
    input  wire logic signed [cfga_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                        valid,
    output cfga_pkg::item_t                             item,
    output cfga_pkg::div_t                              up,
    output cfga_pkg::div_t                              down
);

    logic [cfga_pkg::FRAME_BITS-1:0]     clip_length_reg;
    logic [cfga_pkg::FRAME_BITS-1:0]     fade_in_reg;
    logic [cfga_pkg::FRAME_BITS-1:0]     fade_out_reg;
    logic [cfga_pkg::CLIP_GAIN_BITS-1:0] clip_gain_reg;

    logic                                valid_reg;
    cfga_pkg::item_t                     item_reg;
    cfga_pkg::item_t                     item_next;
    cfga_pkg::div_t                      up_reg;
    cfga_pkg::div_t                      up_next;
    cfga_pkg::div_t                      down_reg;
    cfga_pkg::div_t                      down_next;

    logic [cfga_pkg::FRAME_BITS-1:0]     fi_clamp;
    logic [cfga_pkg::FRAME_BITS-1:0]     fo_clamp;
    logic [cfga_pkg::FRAME_BITS-1:0]     remain;
    logic                                in_clip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_length_reg <= cfga_pkg::FRAME_BITS'(1);
            fade_in_reg     <= '0;
            fade_out_reg    <= '0;
            clip_gain_reg   <= cfga_pkg::CLIP_GAIN_BITS'(4096);
        end
        else if (cfg_we)
        begin
            unique case (cfga_pkg::cfg_reg_t'(cfg_index))
                cfga_pkg::REG_CLIP_LENGTH: clip_length_reg <= cfg_data[cfga_pkg::FRAME_BITS-1:0];
                cfga_pkg::REG_FADE_IN:     fade_in_reg     <= cfg_data[cfga_pkg::FRAME_BITS-1:0];
                cfga_pkg::REG_FADE_OUT:    fade_out_reg    <= cfg_data[cfga_pkg::FRAME_BITS-1:0];
                cfga_pkg::REG_CLIP_GAIN:   clip_gain_reg   <= cfg_data[cfga_pkg::CLIP_GAIN_BITS-1:0];
                default:                   clip_gain_reg   <= clip_gain_reg;
            endcase
        end
    end

    // Clamp fades to the clip and classify the position
    always_comb
    begin
        fi_clamp = (fade_in_reg > clip_length_reg) ? clip_length_reg : fade_in_reg;
        fo_clamp = (fade_out_reg > clip_length_reg) ? clip_length_reg : fade_out_reg;
        remain   = clip_length_reg - position;
        in_clip  = position < clip_length_reg;

        item_next.sample    = sample_in;
        item_next.clip_gain = clip_gain_reg;
        item_next.in_act    = in_clip && (fi_clamp != '0) && (position < fi_clamp);
        item_next.out_act   = in_clip && (fo_clamp != '0) && (remain <= fo_clamp);

        up_next.rem   = position;
        up_next.quo   = '0;
        up_next.den   = fi_clamp;
        down_next.rem = remain - cfga_pkg::FRAME_BITS'(1);
        down_next.quo = '0;
        down_next.den = fo_clamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
            up_reg   <= up_next;
            down_reg <= down_next;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;
    assign up    = up_reg;
    assign down  = down_reg;

endmodule

`default_nettype wire

@@ rtl/core/cfga_div_step.sv @@
`default_nettype none

module cfga_div_step
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   advance,
    input  wire logic   valid_in,
    input  wire cfga_pkg::item_t item_in,
    input  wire cfga_pkg::div_t  up_in,
    input  wire cfga_pkg::div_t  down_in,
    output logic            valid_out,
    output cfga_pkg::item_t item_out,
    output cfga_pkg::div_t  up_out,
    output cfga_pkg::div_t  down_out
);

    logic            valid_reg;
    cfga_pkg::item_t item_reg;
    cfga_pkg::div_t  up_reg;
    cfga_pkg::div_t  up_next;
    cfga_pkg::div_t  down_reg;
    cfga_pkg::div_t  down_next;

    // One restoring step: shift, trial subtract, keep if it fits
    function automatic cfga_pkg::div_t div_bit(input cfga_pkg::div_t d);
        cfga_pkg::div_t                r;
        logic [cfga_pkg::FRAME_BITS:0] shifted;
        logic [cfga_pkg::FRAME_BITS:0] diff;
        shifted = {d.rem, 1'b0};
        diff    = shifted - {1'b0, d.den};
        r.den   = d.den;
        if (shifted >= {1'b0, d.den})
        begin
            r.rem = diff[cfga_pkg::FRAME_BITS-1:0];
            r.quo = {d.quo[cfga_pkg::ENV_FRAC_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = shifted[cfga_pkg::FRAME_BITS-1:0];
            r.quo = {d.quo[cfga_pkg::ENV_FRAC_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        up_next   = div_bit(up_in);
        down_next = div_bit(down_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_in;
            up_reg   <= up_next;
            down_reg <= down_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;
    assign up_out    = up_reg;
    assign down_out  = down_reg;

endmodule

`default_nettype wire

@@ rtl/core/cfga_back.sv @@
`default_nettype none

module cfga_back
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    advance,
    input  wire logic                                    valid_in,
    input  wire cfga_pkg::item_t                         item_in,
    input  wire logic [cfga_pkg::ENV_FRAC_BITS-1:0]      up_quo,
    input  wire logic [cfga_pkg::ENV_FRAC_BITS-1:0]      down_quo,
    output logic                                         valid_out,
    output logic signed [cfga_pkg::SAMPLE_BITS-1:0]      sample_out,
    output logic [cfga_pkg::GAIN_BITS-1:0]               applied_gain,
    output logic                                         saturated
);

    localparam int ENV_BITS  = cfga_pkg::ENV_FRAC_BITS + 1;
    localparam int PROD_BITS = cfga_pkg::SAMPLE_BITS + cfga_pkg::GAIN_BITS + 2;
    localparam int GPROD_BITS = cfga_pkg::CLIP_GAIN_BITS + ENV_BITS;
    localparam int QUO_BITS  = PROD_BITS - 16;
    localparam logic [ENV_BITS-1:0] ENV_ONE = ENV_BITS'(1) << cfga_pkg::ENV_FRAC_BITS;

    // Envelope stage
    logic                                    e_valid_reg;
    logic [ENV_BITS-1:0]                     env_reg;
    logic [ENV_BITS-1:0]                     env_next;
    logic signed [cfga_pkg::SAMPLE_BITS-1:0] e_sample_reg;
    logic [cfga_pkg::CLIP_GAIN_BITS-1:0]     e_cgain_reg;
    logic [ENV_BITS-1:0]                     in_factor;
    logic [2*ENV_BITS-1:0]                   env_prod;

    // Gain stage
    logic                                    g_valid_reg;
    logic [cfga_pkg::GAIN_BITS-1:0]          gain_reg;
    logic [cfga_pkg::GAIN_BITS-1:0]          gain_next;
    logic signed [cfga_pkg::SAMPLE_BITS-1:0] g_sample_reg;
    logic [GPROD_BITS-1:0]                   gain_prod;

    // Product stage
    logic                                    p_valid_reg;
    logic signed [PROD_BITS-1:0]             prod_reg;
    logic signed [PROD_BITS-1:0]             prod_next;
    logic [cfga_pkg::GAIN_BITS-1:0]          p_gain_reg;

    // Output stage
    logic                                    o_valid_reg;
    logic signed [cfga_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic signed [cfga_pkg::SAMPLE_BITS-1:0] sample_next;
    logic [cfga_pkg::GAIN_BITS-1:0]          o_gain_reg;
    logic                                    sat_reg;
    logic                                    sat_next;
    logic signed [QUO_BITS-1:0]              quo;
    logic signed [QUO_BITS-1:0]              max_q;
    logic signed [QUO_BITS-1:0]              min_q;

    always_comb
    begin
        in_factor = item_in.in_act ? {1'b0, up_quo} : ENV_ONE;
        env_prod  = (2*ENV_BITS)'(in_factor) * (2*ENV_BITS)'({1'b0, down_quo});
        if (item_in.out_act)
        begin
            env_next = env_prod[cfga_pkg::ENV_FRAC_BITS +: ENV_BITS];
        end
        else
        begin
            env_next = in_factor;
        end

        gain_prod = GPROD_BITS'(e_cgain_reg) * GPROD_BITS'(env_reg);
        gain_next = gain_prod[(cfga_pkg::ENV_FRAC_BITS-4) +: cfga_pkg::GAIN_BITS];

        prod_next = PROD_BITS'(g_sample_reg) * $signed(PROD_BITS'(gain_reg))
                  + PROD_BITS'(32768);

        // Arithmetic shift floors, giving round half up after the bias
        quo   = QUO_BITS'(prod_reg >>> 16);
        max_q = QUO_BITS'({1'b0, {(cfga_pkg::SAMPLE_BITS-1){1'b1}}});
        min_q = -max_q - QUO_BITS'(1);
        if (quo > max_q)
        begin
            sample_next = {1'b0, {(cfga_pkg::SAMPLE_BITS-1){1'b1}}};
            sat_next    = 1'b1;
        end
        else if (quo < min_q)
        begin
            sample_next = {1'b1, {(cfga_pkg::SAMPLE_BITS-1){1'b0}}};
            sat_next    = 1'b1;
        end
        else
        begin
            sample_next = quo[cfga_pkg::SAMPLE_BITS-1:0];
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            e_valid_reg <= valid_in;
            g_valid_reg <= e_valid_reg;
            p_valid_reg <= g_valid_reg;
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            env_reg      <= env_next;
            e_sample_reg <= item_in.sample;
            e_cgain_reg  <= item_in.clip_gain;
            gain_reg     <= gain_next;
            g_sample_reg <= e_sample_reg;
            prod_reg     <= prod_next;
            p_gain_reg   <= gain_reg;
            sample_reg   <= sample_next;
            o_gain_reg   <= p_gain_reg;
            sat_reg      <= sat_next;
        end
    end

    assign valid_out    = o_valid_reg;
    assign sample_out   = sample_reg;
    assign applied_gain = o_gain_reg;
    assign saturated    = sat_reg;

endmodule

`default_nettype wire

@@ rtl/core/clip_fade_gain_apply.sv @@
// Clip fade and gain: scales each audio sample by the clip gain times a linear
// fade-in / fade-out envelope taken from the sample's frame position.
//
// Input channel: in_valid, in_stall, position, sample_in. An item is taken at
// a clock edge with in_valid high and in_stall low.
// Output channel: out_valid, out_stall, sample_out, applied_gain, saturated.
// Configuration: cfg_we, cfg_index, cfg_data; write only while no item is in
// flight.
//
// Throughput: one item per cycle while the output is not stalled. The depth
// is set by the two restoring dividers, one quotient bit per stage, followed
// by envelope, gain, product and rounding stages.
// Stall: when the output holds an item and out_stall is high, the whole
// pipeline freezes and in_stall rises in the same cycle; nothing is dropped.
// Reset: all stage valids clear, registers return to clip length 1, no fades,
// unity clip gain.
`default_nettype none

module clip_fade_gain_apply
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic [cfga_pkg::FRAME_BITS-1:0]         position,
    input  wire logic signed [cfga_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed [cfga_pkg::SAMPLE_BITS-1:0]      sample_out,
    output logic [cfga_pkg::GAIN_BITS-1:0]               applied_gain,
    output logic                                         saturated,
    input  wire logic                                    cfg_we,
    input  wire logic [cfga_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [cfga_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int STEPS = cfga_pkg::ENV_FRAC_BITS;

    logic            advance;
    logic            accept;
    logic            valid_s [STEPS+1];
    cfga_pkg::item_t item_s  [STEPS+1];
    cfga_pkg::div_t  up_s    [STEPS+1];
    cfga_pkg::div_t  down_s  [STEPS+1];

    // Freeze every stage while the output item waits
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    cfga_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .accept    (accept),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .position  (position),
        .sample_in (sample_in),
        .valid     (valid_s[0]),
        .item      (item_s[0]),
        .up        (up_s[0]),
        .down      (down_s[0])
    );

    for (genvar k = 0; k < STEPS; k++)
    begin : g_div
        cfga_div_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (valid_s[k]),
            .item_in   (item_s[k]),
            .up_in     (up_s[k]),
            .down_in   (down_s[k]),
            .valid_out (valid_s[k+1]),
            .item_out  (item_s[k+1]),
            .up_out    (up_s[k+1]),
            .down_out  (down_s[k+1])
        );
    end

    cfga_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .valid_in     (valid_s[STEPS]),
        .item_in      (item_s[STEPS]),
        .up_quo       (up_s[STEPS].quo),
        .down_quo     (down_s[STEPS].quo),
        .valid_out    (out_valid),
        .sample_out   (sample_out),
        .applied_gain (applied_gain),
        .saturated    (saturated)
    );

endmodule

`default_nettype wire
